// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  // field and register widths
  localparam int GROUPS_W = 5;
  localparam int BPG_W    = 13;
  localparam int BUDGET_W = 17;
  localparam int BLOCK_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GROUPS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_GROUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_BUDGET      = 2'd2;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // reset values and counter ceiling
  localparam logic [GROUPS_W-1:0] GROUPS_RESET = 5'd16;
  localparam logic [BPG_W-1:0]    BPG_RESET    = 13'd4096;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 17'd65536;
  localparam logic [BUDGET_W-1:0] FREE_MAX     = 17'd65536;

  // default geometry
  localparam int DEF_MAX_GROUPS           = 16;
  localparam int DEF_MAX_BLOCKS_PER_GROUP = 4096;
  localparam int DEF_WORD_BITS            = 64;

  typedef struct packed {
    logic [GROUPS_W-1:0] groups_in_use;
    logic [BPG_W-1:0]    group_size;
    logic                budget_load;
    logic [BUDGET_W-1:0] budget;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE_DIV,
    ST_FREE_WR,
    ST_ALLOC_WAIT,
    ST_ALLOC_CHECK,
    ST_ALLOC_CALC,
    ST_RESULT
  } state_t;

  function automatic logic [BUDGET_W-1:0] sat_budget(input logic [BUDGET_W-1:0] v);
    sat_budget = (v > FREE_MAX) ? FREE_MAX : v;
  endfunction

endpackage

// ===== rtl/bitmap_block_allocator_top.sv =====
// Bitmap block allocator. Each request (allocate or free) yields one result:
// the granted block number, a granted flag and the free count after the request.
// A free finds the group that the block falls in, as the compare-subtract unit peels
// one group off the block number per cycle, and, if the block lies within the
// groups in use, clears its bit.
// Allocate scans the map chunk by chunk (one RAM read and one check of up to
// WORD_BITS bits per chunk through the single first-clear-bit finder); a request
// whose answer is known at once goes straight to the result. After reset a
// clearing pass writes every bitmap word (DEPTH words, 1024 by default) with
// in_stall high; configuration writes are taken throughout. Writing free_budget
// reloads the free counter at once. WORD_BITS and MAX_BLOCKS_PER_GROUP are powers
// of two.
module bitmap_block_allocator_top #(
  parameter int MAX_GROUPS           = bba_pkg::DEF_MAX_GROUPS,
  parameter int MAX_BLOCKS_PER_GROUP = bba_pkg::DEF_MAX_BLOCKS_PER_GROUP,
  parameter int WORD_BITS            = bba_pkg::DEF_WORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [bba_pkg::BLOCK_W-1:0]    in_block_number,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bba_pkg::BLOCK_W-1:0]    out_allocated_block,
  output logic                           out_granted,
  output logic [bba_pkg::BUDGET_W-1:0]   out_free_left
);

  localparam int DEPTH = (MAX_GROUPS * MAX_BLOCKS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bba_pkg::GROUPS_W-1:0] groups_r;
  logic [bba_pkg::BPG_W-1:0]    bpg_r;
  bba_pkg::cfg_t                cfg;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // the budget is not held here: a write to it reloads the free counter directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      groups_r <= bba_pkg::GROUPS_RESET;
      bpg_r    <= bba_pkg::BPG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bba_pkg::REG_GROUPS_IN_USE:    groups_r <= cfg_wdata[bba_pkg::GROUPS_W-1:0];
        bba_pkg::REG_BLOCKS_PER_GROUP: bpg_r    <= cfg_wdata[bba_pkg::BPG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.groups_in_use = groups_r;
  assign cfg.group_size    = bpg_r;
  assign cfg.budget_load   = cfg_we && (cfg_index == bba_pkg::REG_FREE_BUDGET);
  assign cfg.budget        = cfg_wdata[bba_pkg::BUDGET_W-1:0];

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bba_ctrl #(
    .MAX_GROUPS          (MAX_GROUPS),
    .MAX_BLOCKS_PER_GROUP(MAX_BLOCKS_PER_GROUP),
    .WORD_BITS           (WORD_BITS),
    .DEPTH               (DEPTH),
    .AW                  (AW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_block_number    (in_block_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_allocated_block(out_allocated_block),
    .out_granted        (out_granted),
    .out_free_left      (out_free_left),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata)
  );

endmodule

// ===== rtl/bba_ram.sv =====
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bba_chunk_find.sv =====
// First clear bit of the chunk that starts at bitoff, counting only bits whose
// offset within the group (base + i) lies below limit.
module bba_chunk_find #(
  parameter int WORD_BITS = 64,
  parameter int CHUNK     = 64,
  parameter int BW        = 18,
  parameter int LW        = $clog2(WORD_BITS),
  parameter int LC        = $clog2(CHUNK)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [LW-1:0]        bitoff,
  input  logic [BW-1:0]        base,
  input  logic [BW-1:0]        limit,
  output logic                 found,
  output logic [LC-1:0]        hit
);

  logic [WORD_BITS-1:0] shifted;
  logic [CHUNK-1:0]     chunk;

  assign shifted = word >> bitoff;
  assign chunk   = shifted[CHUNK-1:0];

  always_comb begin
    found = 1'b0;
    hit   = '0;
    // scan downwards so the lowest clear bit wins
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (!chunk[i] && ((base + BW'(i)) < limit)) begin
        found = 1'b1;
        hit   = LC'(i);
      end
    end
  end

endmodule

// ===== rtl/bba_ctrl.sv =====
module bba_ctrl #(
  parameter int MAX_GROUPS           = bba_pkg::DEF_MAX_GROUPS,
  parameter int MAX_BLOCKS_PER_GROUP = bba_pkg::DEF_MAX_BLOCKS_PER_GROUP,
  parameter int WORD_BITS            = bba_pkg::DEF_WORD_BITS,
  parameter int DEPTH = (MAX_GROUPS * MAX_BLOCKS_PER_GROUP + WORD_BITS - 1) / WORD_BITS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bba_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [bba_pkg::BLOCK_W-1:0]  in_block_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bba_pkg::BLOCK_W-1:0]  out_allocated_block,
  output logic                         out_granted,
  output logic [bba_pkg::BUDGET_W-1:0] out_free_left,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [WORD_BITS-1:0]         ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [WORD_BITS-1:0]         ram_rdata
);

  localparam int LW    = $clog2(WORD_BITS);
  localparam int LBW   = $clog2(MAX_BLOCKS_PER_GROUP);
  localparam int GW    = $clog2(MAX_GROUPS + 1);
  localparam int CHUNK = (WORD_BITS < MAX_BLOCKS_PER_GROUP) ? WORD_BITS : MAX_BLOCKS_PER_GROUP;
  localparam int LC    = $clog2(CHUNK);
  localparam int BW    = ((LBW + 1 > bba_pkg::BLOCK_W) ? LBW + 1 : bba_pkg::BLOCK_W) + 1;
  localparam int IDXW  = GW + LBW + LW;
  localparam int PW    = GW + BW;

  bba_pkg::state_t state_r, state_nxt;

  logic [GW-1:0]               g_r, g_nxt;
  logic [BW-1:0]               b_r, b_nxt;
  logic [LC-1:0]               hit_r, hit_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic [bba_pkg::BUDGET_W-1:0] cnt_r, cnt_nxt;
  logic [bba_pkg::BLOCK_W-1:0] res_alloc_r, res_alloc_nxt;
  logic                        res_granted_r, res_granted_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_load;
  logic [bba_pkg::BLOCK_W-1:0] out_alloc_r;
  logic                        out_granted_r;
  logic [bba_pkg::BUDGET_W-1:0] out_free_r;

  logic [GW-1:0]   ng_eff;
  logic [BW-1:0]   bpg_eff;
  logic [IDXW-1:0] idx;
  logic [LW-1:0]   bitoff;
  logic [AW-1:0]   word_addr;
  logic            found;
  logic [LC-1:0]   hit;
  logic [BW-1:0]   b_end;
  logic [GW:0]     g_inc;
  logic [PW-1:0]   prod;

  // clamp the configured geometry to what the store holds
  assign ng_eff  = (32'(cfg.groups_in_use) > MAX_GROUPS) ? GW'(MAX_GROUPS)
                                                         : GW'(cfg.groups_in_use);
  assign bpg_eff = (32'(cfg.group_size) > MAX_BLOCKS_PER_GROUP)
                   ? BW'(MAX_BLOCKS_PER_GROUP) : BW'(cfg.group_size);

  // bit index g * MAX_BLOCKS_PER_GROUP + b; the read address follows it
  assign idx       = (IDXW'(g_r) << LBW) | IDXW'(b_r[LBW-1:0]);
  assign bitoff    = idx[LW-1:0];
  assign word_addr = idx[LW +: AW];
  assign ram_raddr = word_addr;

  assign b_end = b_r + BW'(CHUNK);
  assign g_inc = (GW + 1)'(g_r) + (GW + 1)'(1);
  assign prod  = PW'(g_r) * PW'(bpg_eff);

  bba_chunk_find #(
    .WORD_BITS(WORD_BITS),
    .CHUNK    (CHUNK),
    .BW       (BW)
  ) u_find (
    .word  (ram_rdata),
    .bitoff(bitoff),
    .base  (b_r),
    .limit (bpg_eff),
    .found (found),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= bba_pkg::sat_budget(bba_pkg::BUDGET_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r           <= g_nxt;
    b_r           <= b_nxt;
    hit_r         <= hit_nxt;
    res_alloc_r   <= res_alloc_nxt;
    res_granted_r <= res_granted_nxt;
    if (out_load) begin
      out_alloc_r   <= res_alloc_r;
      out_granted_r <= res_granted_r;
      out_free_r    <= cnt_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    g_nxt           = g_r;
    b_nxt           = b_r;
    hit_nxt         = hit_r;
    clr_nxt         = clr_r;
    cnt_nxt         = cnt_r;
    res_alloc_nxt   = res_alloc_r;
    res_granted_nxt = res_granted_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_load        = 1'b0;
    in_stall        = 1'b1;
    ram_we          = 1'b0;
    ram_waddr       = word_addr;
    ram_wdata       = ram_rdata;

    case (state_r)
      bba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_IDLE: begin
        in_stall        = 1'b0;
        g_nxt           = '0;
        res_alloc_nxt   = '0;
        res_granted_nxt = 1'b0;
        if (in_valid) begin
          if (in_kind == bba_pkg::KIND_FREE) begin
            b_nxt = BW'(in_block_number);
            if (bpg_eff == '0) begin
              state_nxt = bba_pkg::ST_RESULT;
            end else begin
              state_nxt = bba_pkg::ST_FREE_DIV;
            end
          end else begin
            b_nxt = '0;
            if (cnt_r == '0 || ng_eff == '0 || bpg_eff == '0) begin
              state_nxt = bba_pkg::ST_RESULT;
            end else begin
              state_nxt = bba_pkg::ST_ALLOC_WAIT;
            end
          end
        end
      end
      bba_pkg::ST_FREE_DIV: begin
        // peel one group off the block number per cycle
        if (g_r == ng_eff) begin
          state_nxt = bba_pkg::ST_RESULT;
        end else if (b_r < bpg_eff) begin
          state_nxt = bba_pkg::ST_FREE_WR;
        end else begin
          b_nxt = b_r - bpg_eff;
          g_nxt = g_r + GW'(1);
        end
      end
      bba_pkg::ST_FREE_WR: begin
        ram_we          = 1'b1;
        ram_wdata       = ram_rdata & ~(WORD_BITS'(1) << bitoff);
        res_granted_nxt = 1'b1;
        if (cnt_r < bba_pkg::FREE_MAX) begin
          cnt_nxt = cnt_r + bba_pkg::BUDGET_W'(1);
        end
        state_nxt = bba_pkg::ST_RESULT;
      end
      bba_pkg::ST_ALLOC_WAIT: begin
        state_nxt = bba_pkg::ST_ALLOC_CHECK;
      end
      bba_pkg::ST_ALLOC_CHECK: begin
        if (found) begin
          ram_we          = 1'b1;
          ram_wdata       = ram_rdata | (WORD_BITS'(1) << LW'(bitoff + LW'(hit)));
          cnt_nxt         = cnt_r - bba_pkg::BUDGET_W'(1);
          hit_nxt         = hit;
          res_granted_nxt = 1'b1;
          state_nxt       = bba_pkg::ST_ALLOC_CALC;
        end else if (b_end >= bpg_eff) begin
          if (g_inc >= (GW + 1)'(ng_eff)) begin
            state_nxt = bba_pkg::ST_RESULT;
          end else begin
            g_nxt     = g_inc[GW-1:0];
            b_nxt     = '0;
            state_nxt = bba_pkg::ST_ALLOC_WAIT;
          end
        end else begin
          b_nxt     = b_end;
          state_nxt = bba_pkg::ST_ALLOC_WAIT;
        end
      end
      bba_pkg::ST_ALLOC_CALC: begin
        res_alloc_nxt = bba_pkg::BLOCK_W'(prod + PW'(b_r) + PW'(hit_r));
        state_nxt     = bba_pkg::ST_RESULT;
      end
      bba_pkg::ST_RESULT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bba_pkg::ST_IDLE;
      end
    endcase

    if (cfg.budget_load) begin
      cnt_nxt = bba_pkg::sat_budget(cfg.budget);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_allocated_block = out_alloc_r;
  assign out_granted         = out_granted_r;
  assign out_free_left       = out_free_r;

endmodule

// ===== rtl/bba_checker.sv =====
module bba_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_kind,
  input logic [bba_pkg::BLOCK_W-1:0]    in_block_number,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bba_pkg::BLOCK_W-1:0]    out_allocated_block,
  input logic                           out_granted,
  input logic [bba_pkg::BUDGET_W-1:0]   out_free_left
);

  // the clearing pass follows reset, so no request is taken straight after it
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken during bitmap clearing pass");

  // one request at a time: busy in the cycle after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  a_refused_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_allocated_block == '0))
    else $error("refused request carries a block number");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_allocated_block)
                                  && $stable(out_granted) && $stable(out_free_left)))
    else $error("stalled result changed");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);
